[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ordered value list.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ovl_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered value list package
// Request and result types, request codes and status codes.
// ----------------------------------------------------------------------------
package ovl_pkg;

    typedef enum logic [2:0] {
        REQ_APPEND   = 3'd0,
        REQ_PREPEND  = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_POP      = 3'd3,
        REQ_CONTAINS = 3'd4
    } ovl_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } ovl_status_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } ovl_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] result_value;
        logic [4:0]         count;
    } ovl_rsp_t;

    typedef struct packed {
        logic prepend;
        logic append;
        logic remove;
    } ovl_ctrl_t;

endpackage

[hdl/ovl_cell.sv]
// ----------------------------------------------------------------------------
// Ordered value list cell
// Holds one entry, compares it with the request value and shifts with its
// neighbors on prepend and remove.
// ----------------------------------------------------------------------------
module ovl_cell #(
    parameter int INDEX      = 0,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 5
) (
    input  logic                  clk,
    input  ovl_pkg::ovl_ctrl_t    ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic                  seen_in,
    output logic [VALUE_BITS-1:0] value,
    output logic                  seen_out,
    output logic [VALUE_BITS-1:0] tail_value
);

    localparam logic [CNT_W:0] IDX      = (CNT_W + 1)'(INDEX);
    localparam logic [CNT_W:0] IDX_NEXT = (CNT_W + 1)'(INDEX + 1);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [CNT_W:0]        count_ext;
    logic                  valid;
    logic                  match;
    logic                  at_count;
    logic                  is_tail;

    assign count_ext = {1'b0, count};
    assign valid     = count_ext > IDX;
    assign at_count  = count_ext == IDX;
    assign is_tail   = count_ext == IDX_NEXT;
    assign match     = valid && (value_reg == in_value);
    assign seen_out  = seen_in | match;

    always_comb
    begin
        priority if (ctrl.prepend)
        begin
            value_next = (INDEX == 0) ? in_value : left_value;
        end
        else if (ctrl.append && at_count)
        begin
            value_next = in_value;
        end
        else if (ctrl.remove && seen_out)
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value      = value_reg;
    assign tail_value = is_tail ? value_reg : '0;

endmodule

[hdl/ordered_value_list.sv]
// ----------------------------------------------------------------------------
// Ordered value list
// The result strobe done rises in the cycle after start is accepted.
// Throughput: one request per cycle; busy stays low and the receiver cannot
// stall. The cell chain compares every entry in the accepting cycle and
// shifts entries on prepend and remove. Reset clears the count and the
// result strobe; entry contents are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_value_list #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ovl_pkg::ovl_req_t request,
    output logic              done,
    output ovl_pkg::ovl_rsp_t result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    ovl_pkg::ovl_rsp_t     result_reg;
    ovl_pkg::ovl_rsp_t     result_next;
    ovl_pkg::ovl_ctrl_t    ctrl;

    logic [VALUE_BITS+31:0] in_ext;
    logic [VALUE_BITS-1:0]  in_value;
    logic [VALUE_BITS-1:0]  cell_value [DEPTH];
    logic [VALUE_BITS-1:0]  cell_tail  [DEPTH];
    logic [DEPTH:0]         seen;
    logic [VALUE_BITS-1:0]  tail_value;
    logic [VALUE_BITS+31:0] tail_ext;
    logic [VALUE_BITS+31:0] ones_ext;
    logic [CNT_W+4:0]       count_ext;
    logic                   full;
    logic                   empty;
    logic                   hit;

    assign in_ext   = {{VALUE_BITS{1'b0}}, request.value};
    assign in_value = in_ext[VALUE_BITS-1:0];
    assign full     = count_reg == FULL_COUNT;
    assign empty    = count_reg == '0;
    assign seen[0]  = 1'b0;
    assign hit      = seen[DEPTH];

    always_comb
    begin
        ctrl.prepend = start && (request.req_type == ovl_pkg::REQ_PREPEND) && !full;
        ctrl.append  = start && (request.req_type == ovl_pkg::REQ_APPEND) && !full;
        ctrl.remove  = start && (request.req_type == ovl_pkg::REQ_REMOVE);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ovl_cell #(
            .INDEX      (i),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .in_value    (in_value),
            .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
            .seen_in     (seen[i]),
            .value       (cell_value[i]),
            .seen_out    (seen[i+1]),
            .tail_value  (cell_tail[i])
        );
    end

    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    assign tail_ext = {32'd0, tail_value};
    assign ones_ext = {32'd0, {VALUE_BITS{1'b1}}};

    always_comb
    begin
        count_next               = count_reg;
        result_next.status       = ovl_pkg::ST_OK;
        result_next.found        = 1'b0;
        result_next.result_value = '0;
        unique case (request.req_type)
            ovl_pkg::REQ_APPEND, ovl_pkg::REQ_PREPEND:
            begin
                if (full)
                begin
                    result_next.status = ovl_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ovl_pkg::REQ_REMOVE:
            begin
                if (empty)
                begin
                    result_next.status = ovl_pkg::ST_EMPTY;
                end
                else if (!hit)
                begin
                    result_next.status = ovl_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    result_next.found = 1'b1;
                    count_next        = count_reg - 1'b1;
                end
            end
            ovl_pkg::REQ_POP:
            begin
                if (empty)
                begin
                    result_next.status       = ovl_pkg::ST_EMPTY;
                    result_next.result_value = ones_ext[31:0];
                end
                else
                begin
                    result_next.result_value = tail_ext[31:0];
                    count_next               = count_reg - 1'b1;
                end
            end
            ovl_pkg::REQ_CONTAINS:
            begin
                if (empty)
                begin
                    result_next.status = ovl_pkg::ST_EMPTY;
                end
                else if (!hit)
                begin
                    result_next.status = ovl_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    result_next.found = 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        count_ext         = {5'd0, count_next};
        result_next.count = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT, "count exceeds depth")
    `ASSERT_NEXT(a_done_follows, clk, rst_n, start, done, "request without result strobe")
    `ASSERT_NEXT(a_count_held, clk, rst_n, !start, $stable(count_reg), "count moved while idle")
    `ASSERT_IMPLIES(a_full_status, clk, rst_n, done && result.status == ovl_pkg::ST_FULL, count_reg == FULL_COUNT, "full status with room left")

endmodule
